### sv/dlr_pkg.sv
// dlr_pkg: shared types and constants for the direct line rasterizer
// holds the item structs, the kind codes and the default fraction width
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dlr_pkg;

	localparam int COORD_BITS    = 12;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	typedef struct packed {
		logic                         kind;
		logic signed [COORD_BITS-1:0] x_start;
		logic signed [COORD_BITS-1:0] y_start;
		logic signed [COORD_BITS-1:0] x_end;
		logic signed [COORD_BITS-1:0] y_end;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
		logic                         last_point;
	} pix_t;

endpackage
`default_nettype wire

### sv/dlr_div.sv
// dlr_div: iterative restoring divider, one quotient bit per cycle
// unsigned num / den, quotient valid with a one-cycle done pulse
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module dlr_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

### sv/dlr_minor.sv
// dlr_minor: minor coordinate from ratio times major offset, rounded half up
// registered product, then rounding shift and origin add
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module dlr_minor #(
	parameter int COORD_W = 12,
	parameter int FRAC_W  = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [FRAC_W+1:0]  ratio,
	input  logic        [COORD_W-1:0] offset,
	input  logic signed [COORD_W-1:0] origin,
	output logic signed [COORD_W-1:0] minor
);
	localparam int PW = FRAC_W + 2 + COORD_W + 1;

	logic signed [PW-1:0] half;
	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] rounded;
	logic signed [PW-1:0] scaled;
	logic signed [COORD_W:0] off_s;

	assign half  = PW'(1) <<< (FRAC_W - 1);
	assign off_s = {1'b0, offset};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(ratio) * PW'(off_s);
		end
	end

	assign rounded = prod_s1 + half;
	assign scaled  = rounded >>> FRAC_W;
	assign minor   = origin + scaled[COORD_W-1:0];

endmodule
`default_nettype wire

### sv/direct_line_rasterizer.sv
// direct_line_rasterizer: slope-intercept line rasterizer, at most one point per item
// start item: axis choice, endpoint ordering, divider (one bit a cycle), emit, output register;
// a line with equal endpoints skips the divider
// advance item on an active line: multiply, round and emit states, then the output register
// one item at a time; cmd_ready is low while an item is in work; a held output adds its stall
// async reset clears the sequencer, line status and output valid; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module direct_line_rasterizer #(
	parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  dlr_pkg::cmd_t cmd,
	output logic          pix_valid,
	input  logic          pix_ready,
	output dlr_pkg::pix_t pix
);
	import dlr_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int NUM_W = COORD_BITS + FRAC_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_AXIS  = 3'd1;
	localparam logic [2:0] ST_ORDER = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_RND   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic       line_active_q;
	logic       pix_valid_q;
	pix_t       pix_q;

	logic signed [C-1:0] xs_q, ys_q, xe_q, ye_q;
	logic signed [C-1:0] maj_a_q, min_a_q, maj_b_q, min_b_q;
	logic                steep_axis_q;
	logic signed [C-1:0] major_origin_q, minor_origin_q;
	logic signed [C-1:0] major_current_q, major_final_q;
	logic signed [FRAC_BITS+1:0] step_ratio_q;
	logic                min_neg_q;
	logic        [C-1:0] offset_q;
	logic signed [C-1:0] emit_major_q, emit_minor_q;
	logic                emit_last_q;

	// axis choice
	logic signed [C:0] dx, dy;
	logic        [C:0] adx, ady;
	logic              steep;

	assign dx    = {xe_q[C-1], xe_q} - {xs_q[C-1], xs_q};
	assign dy    = {ye_q[C-1], ye_q} - {ys_q[C-1], ys_q};
	assign adx   = dx[C] ? (C+1)'(-dx) : dx;
	assign ady   = dy[C] ? (C+1)'(-dy) : dy;
	assign steep = ady > adx;

	// endpoint ordering along the major axis
	logic                swap;
	logic signed [C-1:0] o0, o1, m0, m1;
	logic signed [C:0]   dmaj, dmin;
	logic        [C:0]   admin;
	logic                dmaj_zero;

	assign swap      = maj_a_q > maj_b_q;
	assign o0        = swap ? maj_b_q : maj_a_q;
	assign o1        = swap ? maj_a_q : maj_b_q;
	assign m0        = swap ? min_b_q : min_a_q;
	assign m1        = swap ? min_a_q : min_b_q;
	assign dmaj      = {o1[C-1], o1} - {o0[C-1], o0};
	assign dmin      = {m1[C-1], m1} - {m0[C-1], m0};
	assign admin     = dmin[C] ? (C+1)'(-dmin) : dmin;
	assign dmaj_zero = dmaj == '0;

	// divider
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [NUM_W-1:0] div_num;
	logic [NUM_W-1:0] div_quot;
	logic signed [FRAC_BITS+1:0] ratio_mag;

	assign div_start = (state_q == ST_ORDER) && !dmaj_zero;
	assign div_num   = {admin[C-1:0], {FRAC_BITS{1'b0}}};
	assign ratio_mag = {1'b0, div_quot[FRAC_BITS:0]};

	dlr_div #(
		.NUM_W(NUM_W),
		.DEN_W(C)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (dmaj[C-1:0]),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (div_quot)
	);

	// minor coordinate
	logic signed [C-1:0] minor_val;

	dlr_minor #(
		.COORD_W(C),
		.FRAC_W (FRAC_BITS)
	) u_minor (
		.clk   (clk),
		.en    (state_q == ST_MUL),
		.ratio (step_ratio_q),
		.offset(offset_q),
		.origin(minor_origin_q),
		.minor (minor_val)
	);

	// advance step
	logic signed [C-1:0] major_next;
	logic signed [C:0]   off_full;
	logic                adv_last;
	logic                cmd_take;
	logic                emit_go;

	assign major_next = major_current_q + C'(1);
	assign off_full   = {major_next[C-1], major_next} - {major_origin_q[C-1], major_origin_q};
	assign adv_last   = major_next >= major_final_q;
	assign cmd_ready  = state_q == ST_IDLE;
	assign cmd_take   = cmd_valid && cmd_ready;
	assign emit_go    = (state_q == ST_EMIT) && (!pix_valid_q || pix_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			line_active_q <= 1'b0;
			pix_valid_q   <= 1'b0;
		end else begin
			if (emit_go) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if (cmd.kind == KIND_START) begin
							state_q <= ST_AXIS;
						end else if (line_active_q) begin
							if (adv_last) begin
								line_active_q <= 1'b0;
							end
							state_q <= ST_MUL;
						end
					end
				end
				ST_AXIS: begin
					state_q <= ST_ORDER;
				end
				ST_ORDER: begin
					line_active_q <= !dmaj_zero;
					state_q       <= dmaj_zero ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_MUL: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.kind == KIND_START) begin
			xs_q <= cmd.x_start;
			ys_q <= cmd.y_start;
			xe_q <= cmd.x_end;
			ye_q <= cmd.y_end;
		end
		if (cmd_take && cmd.kind == KIND_ADVANCE && line_active_q) begin
			major_current_q <= major_next;
			offset_q        <= off_full[C-1:0];
			emit_major_q    <= major_next;
			emit_last_q     <= adv_last;
		end
		if (state_q == ST_AXIS) begin
			steep_axis_q <= steep;
			maj_a_q      <= steep ? ys_q : xs_q;
			min_a_q      <= steep ? xs_q : ys_q;
			maj_b_q      <= steep ? ye_q : xe_q;
			min_b_q      <= steep ? xe_q : ye_q;
		end
		if (state_q == ST_ORDER) begin
			major_origin_q  <= o0;
			minor_origin_q  <= m0;
			major_current_q <= o0;
			major_final_q   <= o1;
			min_neg_q       <= dmin[C];
			emit_major_q    <= o0;
			emit_minor_q    <= m0;
			emit_last_q     <= dmaj_zero;
			if (dmaj_zero) begin
				step_ratio_q <= '0;
			end
		end
		if (state_q == ST_DIV && div_done) begin
			step_ratio_q <= min_neg_q ? (FRAC_BITS+2)'(-ratio_mag) : ratio_mag;
		end
		if (state_q == ST_RND) begin
			emit_minor_q <= minor_val;
		end
		if (emit_go) begin
			pix_q.pixel_x    <= steep_axis_q ? emit_minor_q : emit_major_q;
			pix_q.pixel_y    <= steep_axis_q ? emit_major_q : emit_minor_q;
			pix_q.last_point <= emit_last_q;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

`ifndef SYNTHESIS
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(div_busy || div_done) |-> state_q == ST_DIV)
		else $error("divider running outside the divide state");

	a_active_before_final: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> major_current_q < major_final_q)
		else $error("active line already at its final point");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_last_q) |-> !line_active_q)
		else $error("last point pending while line still active");

	a_emit_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> pix_valid_q && state_q == ST_IDLE)
		else $error("emitted item did not reach the output register");
`endif

endmodule
`default_nettype wire

### tb/direct_line_rasterizer_checker.sv
// direct_line_rasterizer_checker: watches both channels, predicts every point and compares
// keeps its own copy of the line state; hands the mismatch count and open points to the top
// depends on dlr_pkg
`timescale 1ns / 1ps
module direct_line_rasterizer_checker #(
	parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_ready,
	input  dlr_pkg::cmd_t cmd,
	input  logic          pix_valid,
	input  logic          pix_ready,
	input  dlr_pkg::pix_t pix,
	input  logic          end_check,
	output int            outstanding,
	output int            miss_count
);
	import dlr_pkg::*;

	logic                         steep   = 1'b0;
	logic                         active  = 1'b0;
	logic signed [COORD_BITS-1:0] maj_org = '0;
	logic signed [COORD_BITS-1:0] min_org = '0;
	logic signed [COORD_BITS-1:0] maj_cur = '0;
	logic signed [COORD_BITS-1:0] maj_fin = '0;
	logic signed [FRAC_BITS+1:0]  slope   = '0;
	pix_t                         point_q[$];
	pix_t                         want_pt;

	initial begin
		outstanding = 0;
		miss_count = 0;
	end

	task automatic report_mismatch(input string what);
		if (miss_count < 40) $display("%0t dlr_chk: %s", $time, what);
		miss_count++;
	endtask

	task automatic plot_item(input cmd_t c);
		int     xs, ys, xe, ye, a0, b0, a1, b1, t, dx, dy, maj_pt, min_pt;
		longint dmaj, dmin, scaled, ratio;
		pix_t   p;
		if (c.kind == KIND_START) begin
			xs = $signed(c.x_start);
			ys = $signed(c.y_start);
			xe = $signed(c.x_end);
			ye = $signed(c.y_end);
			dx = xe - xs;
			dy = ye - ys;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			steep = dy > dx;
			if (steep) begin
				a0 = ys; b0 = xs; a1 = ye; b1 = xe;
			end else begin
				a0 = xs; b0 = ys; a1 = xe; b1 = ye;
			end
			if (a0 > a1) begin
				t = a0; a0 = a1; a1 = t;
				t = b0; b0 = b1; b1 = t;
			end
			dmaj = a1 - a0;
			dmin = b1 - b0;
			ratio = (dmaj > 0) ? (dmin <<< FRAC_BITS) / dmaj : 0;
			slope = ratio[FRAC_BITS+1:0];
			maj_org = a0[COORD_BITS-1:0];
			min_org = b0[COORD_BITS-1:0];
			maj_cur = a0[COORD_BITS-1:0];
			maj_fin = a1[COORD_BITS-1:0];
			active = (a0 != a1);
			maj_pt = a0;
			min_pt = b0;
			p.last_point = !active;
		end else if (active) begin
			maj_cur = maj_cur + 12'sd1;
			p.last_point = (maj_cur >= maj_fin);
			if (p.last_point) active = 1'b0;
			scaled = longint'(slope) * (int'(maj_cur) - int'(maj_org));
			scaled = (scaled + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			maj_pt = int'(maj_cur);
			min_pt = int'(min_org) + int'(scaled);
		end else begin
			return;
		end
		p.pixel_x = steep ? min_pt[COORD_BITS-1:0] : maj_pt[COORD_BITS-1:0];
		p.pixel_y = steep ? maj_pt[COORD_BITS-1:0] : min_pt[COORD_BITS-1:0];
		point_q.push_back(p);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steep = 1'b0;
			active = 1'b0;
			maj_org = '0;
			min_org = '0;
			maj_cur = '0;
			maj_fin = '0;
			slope = '0;
			point_q.delete();
		end else begin
			if (pix_valid && pix_ready) begin
				if (point_q.size() == 0) begin
					report_mismatch($sformatf("point (%0d,%0d) last %0b with none expected",
						pix.pixel_x, pix.pixel_y, pix.last_point));
				end else begin
					want_pt = point_q.pop_front();
					if (pix.pixel_x !== want_pt.pixel_x)
						report_mismatch($sformatf("pixel_x %0d, want %0d",
							pix.pixel_x, want_pt.pixel_x));
					if (pix.pixel_y !== want_pt.pixel_y)
						report_mismatch($sformatf("pixel_y %0d, want %0d",
							pix.pixel_y, want_pt.pixel_y));
					if (pix.last_point !== want_pt.last_point)
						report_mismatch($sformatf("last_point %0b, want %0b at (%0d,%0d)",
							pix.last_point, want_pt.last_point,
							want_pt.pixel_x, want_pt.pixel_y));
				end
			end
			if (cmd_valid && cmd_ready) plot_item(cmd);
		end
		outstanding = point_q.size();
	end

	always @(posedge end_check) begin
		if (point_q.size() != 0)
			report_mismatch($sformatf("%0d points never came", point_q.size()));
	end

endmodule

### tb/direct_line_rasterizer_tb.sv
// direct_line_rasterizer_tb: drives start and advance items into the rasterizer
// with random idling and back-pressure; checking is done by direct_line_rasterizer_checker
// depends on dlr_pkg, direct_line_rasterizer and direct_line_rasterizer_checker
`timescale 1ns / 1ps
module direct_line_rasterizer_tb;
	import dlr_pkg::*;

	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 400;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic pix_valid;
	logic pix_ready = 1'b0;
	pix_t pix;
	logic end_check = 1'b0;
	int   outstanding;
	int   miss_count;
	bit   tx_idle    = 1'b1;
	bit   rx_idle    = 1'b1;
	bit   rx_hold    = 1'b0;
	int   item_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	direct_line_rasterizer #(.FRAC_BITS(FRAC)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	direct_line_rasterizer_checker #(.FRAC_BITS(FRAC)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix),
		.end_check   (end_check),
		.outstanding (outstanding),
		.miss_count  (miss_count)
	);

	function automatic int rand_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic int near(input int v, input int reach);
		int r;
		r = v + int'($urandom_range(0, 2 * reach)) - reach;
		if (r > 2047) r = 2047;
		if (r < -2048) r = -2048;
		return r;
	endfunction

	function automatic cmd_t rand_cmd(input logic kind);
		cmd_t c;
		c.kind = kind;
		c.x_start = COORD_BITS'($urandom);
		c.y_start = COORD_BITS'($urandom);
		c.x_end = COORD_BITS'($urandom);
		c.y_end = COORD_BITS'($urandom);
		return c;
	endfunction

	function automatic cmd_t make_start(input int xs, input int ys, input int xe, input int ye);
		cmd_t c;
		c.kind = KIND_START;
		c.x_start = xs[COORD_BITS-1:0];
		c.y_start = ys[COORD_BITS-1:0];
		c.x_end = xe[COORD_BITS-1:0];
		c.y_end = ye[COORD_BITS-1:0];
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c, input bit counts);
		@(negedge clk);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			cmd_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		cmd = c;
		cmd_valid = 1'b1;
		do @(posedge clk); while (!cmd_ready);
		if (counts) item_count++;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic walk_line(input int xs, input int ys, input int xe, input int ye,
		input int steps);
		send_cmd(make_start(xs, ys, xe, ye), 1'b1);
		repeat (steps) send_cmd(rand_cmd(KIND_ADVANCE), 1'b1);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				pix_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				pix_ready = 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			pix_ready = 1'b1;
		end
	end

	initial begin
		#2_000_000;
		$display("[direct_line_rasterizer] ERROR");
		$finish;
	end

	initial begin
		int xs, ys, xe, ye, d, dx, dy, span, steps;
		bit hold_done, pause_done;
		hold_done = 1'b0;
		pause_done = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner endpoints, abandoned mid-line
		walk_line(-2048, -2048, 2047, 2047, 2);
		walk_line(2047, -2048, -2048, 2047, 1);
		// equal endpoints, then advance while idle
		walk_line(-2048, 2047, -2048, 2047, 0);
		send_cmd(rand_cmd(KIND_ADVANCE), 1'b0);
		// vertical line run to its end, then advance while idle
		walk_line(5, -2, 5, 1, 3);
		send_cmd(rand_cmd(KIND_ADVANCE), 1'b0);
		// reversed endpoints
		walk_line(3, 1, -2, -1, 5);
		// rounding at exactly one half, both signs
		walk_line(0, 0, 2, 1, 2);
		walk_line(0, 0, 2, -1, 2);
		drain();

		while (item_count < ITEM_TARGET) begin
			if (item_count >= ITEM_TARGET - 80) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			if (!hold_done && item_count >= 150) begin
				hold_done = 1'b1;
				rx_hold = 1'b1;
			end
			if (!pause_done && item_count >= 260) begin
				pause_done = 1'b1;
				drain();
			end
			if ($urandom_range(0, 9) == 0) begin
				send_cmd(rand_cmd(1'($urandom_range(0, 1))), 1'b1);
			end else begin
				xs = rand_coord();
				ys = rand_coord();
				case ($urandom_range(0, 7))
					0: begin
						xe = rand_coord();
						ye = rand_coord();
					end
					1: begin
						xe = xs;
						ye = near(ys, 20);
					end
					2: begin
						xe = near(xs, 20);
						ye = ys;
					end
					3: begin
						d = $urandom_range(0, 15);
						xe = near($urandom_range(0, 1) ? xs + d : xs - d, 0);
						ye = near($urandom_range(0, 1) ? ys + d : ys - d, 0);
					end
					default: begin
						xe = near(xs, 24);
						ye = near(ys, 24);
					end
				endcase
				dx = xe - xs;
				dy = ye - ys;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				span = (dx > dy) ? dx : dy;
				if ($urandom_range(0, 3) == 0)
					steps = $urandom_range(0, (span < 8) ? span : 8);
				else
					steps = (span < 40) ? span : 40;
				walk_line(xs, ys, xe, ye, steps);
				if (steps == span)
					repeat ($urandom_range(0, 2)) send_cmd(rand_cmd(KIND_ADVANCE), 1'b0);
			end
		end

		drain();
		repeat (64) @(negedge clk);
		end_check = 1'b1;
		@(negedge clk);
		if (miss_count == 0)
			$display("[direct_line_rasterizer] OK");
		else
			$display("[direct_line_rasterizer] ERROR");
		$finish;
	end

endmodule
